@@ rtl/sph_pkg.sv @@
// Package for site_pattern_probs_hadamard: widths, Q30 fraction bits, leaf-order tables.
// No dependencies.
`default_nettype none
package sph_pkg;
  localparam int IN_FRAC_BITS_DEF = 16;
  localparam int QBITS = 30;
  localparam int NPAT = 16;
  localparam int PW = 4;
  localparam int OUT_W = 32;
  // Leaf-order codes
  localparam logic [1:0] ORD_IDENT = 2'd0;
  localparam logic [1:0] ORD_SWAP = 2'd1;
  localparam logic [1:0] ORD_CYCLE = 2'd2;

  // Source index of output position k under each leaf order
  function automatic logic [PW-1:0] src_index(input logic [1:0] ord, input logic [PW-1:0] k);
    logic [PW-1:0] r;
    r = k;
    case (ord)
      ORD_SWAP: r = {k[3], k[1], k[2], k[0]};
      ORD_CYCLE: r = {k[3], k[0], k[2], k[1]};
      default: r = k;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/site_pattern_probs_hadamard.sv @@
// Site pattern probabilities of a four-leaf model via a 16-point Hadamard transform.
// Depends on sph_pkg.
//
// Usage: one parameter set (g, x1..x5, leaf_order) enters on the input channel
// (valid/stall); sixteen probability words leave on the output channel, one per
// cycle while out_stall is low, pattern_index 0..15, last_pattern on the sixteenth.
// The single output port drains sixteen words per parameter set; the next set is
// taken while the current one drains. A set passes six registered arithmetic
// stages; the transform of the last one loads the result bank feeding the ports.
// The arithmetic pipeline advances only when its last stage can hand over to
// the result bank; a stall at the output holds the word on the ports and backs
// up the pipeline, nothing is lost or repeated.
// Reset (rst, synchronous, active high) clears all valid bits and the counter.
`default_nettype none
module site_pattern_probs_hadamard #(
  parameter int IN_FRAC_BITS = sph_pkg::IN_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [IN_FRAC_BITS:0] gamma_factor,
  input  wire logic [IN_FRAC_BITS:0] edge_one,
  input  wire logic [IN_FRAC_BITS:0] edge_two,
  input  wire logic [IN_FRAC_BITS:0] edge_three,
  input  wire logic [IN_FRAC_BITS:0] edge_four,
  input  wire logic [IN_FRAC_BITS:0] edge_five,
  input  wire logic [1:0] leaf_order,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [sph_pkg::PW-1:0] pattern_index,
  output logic signed [sph_pkg::OUT_W-1:0] probability,
  output logic last_pattern
);
  import sph_pkg::*;

  localparam int SH = QBITS - IN_FRAC_BITS;
  localparam logic [31:0] QONE = 32'h4000_0000;
  localparam logic [63:0] QHALF = 64'h2000_0000;

  typedef logic [30:0] uq_t;           // unsigned factor in [0,1], Q30
  typedef logic signed [36:0] sq_t;    // signed Q30 sums

  // Rounded product of two [0,1] factors
  function automatic uq_t fmul(input uq_t a, input uq_t b);
    logic [63:0] p;
    p = {33'd0, a} * {33'd0, b} + QHALF;
    return p[60:30];
  endfunction

  // Rounded product of signed value and [0,1] factor, ties away from zero
  function automatic sq_t qmul(input sq_t a, input uq_t b);
    logic [36:0] mag;
    logic [67:0] p;
    logic [36:0] r;
    mag = a[36] ? 37'(-a) : 37'(a);
    p = {31'd0, mag} * {37'd0, b} + {4'd0, QHALF};
    r = p[66:30];
    return a[36] ? sq_t'(-r) : sq_t'(r);
  endfunction

  function automatic uq_t to_q30(input logic [IN_FRAC_BITS:0] v);
    logic [IN_FRAC_BITS:0] c;
    c = v[IN_FRAC_BITS] ? {1'b1, {IN_FRAC_BITS{1'b0}}} : v;
    return uq_t'(c) << SH;
  endfunction

  logic adv;  // pipeline advance

  // ---------------- stage 1: convert, first products
  logic v1;
  uq_t g1, x2_1, x3_1, x4_1, x5_1, x23_1, x12_1, a0011_1, a1100_1, t1_1;
  logic [1:0] ord1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= in_valid;
    if (adv) begin
      g1 <= to_q30(gamma_factor);
      x2_1 <= to_q30(edge_two);
      x3_1 <= to_q30(edge_three); x4_1 <= to_q30(edge_four);
      x5_1 <= to_q30(edge_five);
      x23_1 <= fmul(to_q30(edge_two), to_q30(edge_three));
      x12_1 <= fmul(to_q30(edge_one), to_q30(edge_two));
      a0011_1 <= fmul(to_q30(edge_four), to_q30(edge_five));
      a1100_1 <= fmul(to_q30(edge_one), to_q30(edge_three));
      t1_1 <= fmul(to_q30(gamma_factor), to_q30(gamma_factor));
      ord1 <= leaf_order;
    end
  end

  // ---------------- stage 2
  logic v2;
  uq_t g2, x3_2, x5_2, a0011_2, a1100_2, t1_2, t2_2;
  uq_t a0101_2, a0110_2, a0011x2_2, a1001_2, a1010_2, a1111_2;
  logic [1:0] ord2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      g2 <= g1; x3_2 <= x3_1; x5_2 <= x5_1; a0011_2 <= a0011_1; a1100_2 <= a1100_1;
      t1_2 <= t1_1; t2_2 <= uq_t'(QONE[30:0] - t1_1);
      a0101_2 <= fmul(x23_1, x4_1);
      a0110_2 <= fmul(x23_1, x5_1);
      a0011x2_2 <= fmul(a0011_1, x2_1);
      a1001_2 <= fmul(x12_1, x4_1);
      a1010_2 <= fmul(x12_1, x5_1);
      a1111_2 <= fmul(a0011_1, a1100_1);
      ord2 <= ord1;
    end
  end

  // ---------------- stage 3
  logic v3;
  uq_t g3, t1_3, t2_3, a0011_3, a1100_3, a0101_3, a0110_3, a1001_3, a1010_3;
  uq_t a0111_3, a1101_3, a1110_3, a1011_3, t2sq_3, a1111_3, x5_3;
  logic [1:0] ord3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      g3 <= g2; t1_3 <= t1_2; t2_3 <= t2_2; a0011_3 <= a0011_2; a1100_3 <= a1100_2;
      a0101_3 <= a0101_2; a0110_3 <= a0110_2; a1001_3 <= a1001_2; a1010_3 <= a1010_2;
      a1111_3 <= a1111_2; x5_3 <= x5_2;
      a0111_3 <= fmul(a0011x2_2, x3_2);
      a1101_3 <= fmul(a1001_2, x3_2);
      a1110_3 <= fmul(a1010_2, x3_2);
      a1011_3 <= fmul(a1001_2, x5_2);
      t2sq_3 <= fmul(t2_2, t2_2);
      ord3 <= ord2;
    end
  end

  // ---------------- stage 4: dall, combined sums, first mix products
  logic v4;
  uq_t g4, t1_4, t2_4, t2sq_4, a1111_4;
  sq_t s3_4, s5_4, s6_4, s9_4, s10_4, s12_4, s7_4, s11_4, s13_4, s14_4, s15p_4;
  logic [1:0] ord4;
  sq_t s15pre;
  always_comb begin
    s15pre = sq_t'(a0011_3) + sq_t'(a0101_3) + sq_t'(a0110_3) + sq_t'(a1001_3)
           + sq_t'(a1010_3) + sq_t'(a1100_3)
           - 2 * (sq_t'(a0111_3) + sq_t'(a1011_3) + sq_t'(a1101_3) + sq_t'(a1110_3));
  end
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      g4 <= g3; t1_4 <= t1_3; t2_4 <= t2_3; t2sq_4 <= t2sq_3; a1111_4 <= a1111_3;
      s3_4 <= qmul(sq_t'(a0011_3), t2_3);
      s5_4 <= qmul(sq_t'(a0101_3), t2_3);
      s6_4 <= qmul(sq_t'(a0110_3), t2_3);
      s9_4 <= qmul(sq_t'(a1001_3), t2_3);
      s10_4 <= qmul(sq_t'(a1010_3), t2_3);
      s12_4 <= qmul(sq_t'(a1100_3), t2_3);
      s7_4 <= sq_t'(a0011_3) + sq_t'(a0101_3) + sq_t'(a0110_3) - 2 * sq_t'(a0111_3);
      s11_4 <= sq_t'(a0011_3) + sq_t'(a1001_3) + sq_t'(a1010_3) - 2 * sq_t'(a1011_3);
      s13_4 <= sq_t'(a0101_3) + sq_t'(a1001_3) + sq_t'(a1100_3) - 2 * sq_t'(a1101_3);
      s14_4 <= sq_t'(a0110_3) + sq_t'(a1010_3) + sq_t'(a1100_3) - 2 * sq_t'(a1110_3);
      s15p_4 <= s15pre + 4 * sq_t'(fmul(a1101_3, x5_3));
      ord4 <= ord3;
    end
  end

  // ---------------- stage 5: mix of combined terms
  logic v5;
  sq_t q_5 [NPAT];
  sq_t m7_5, m11_5, m13_5, m14_5, m15_5, f15_5;
  uq_t g5, t1_5;
  logic [1:0] ord5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (adv) v5 <= v4;
    if (adv) begin
      g5 <= g4; t1_5 <= t1_4; ord5 <= ord4;
      q_5[0] <= sq_t'(QONE);
      q_5[1] <= sq_t'(g4); q_5[2] <= sq_t'(g4); q_5[4] <= sq_t'(g4); q_5[8] <= sq_t'(g4);
      q_5[3] <= sq_t'(t1_4) + s3_4;
      q_5[5] <= sq_t'(t1_4) + s5_4;
      q_5[6] <= sq_t'(t1_4) + s6_4;
      q_5[9] <= sq_t'(t1_4) + s9_4;
      q_5[10] <= sq_t'(t1_4) + s10_4;
      q_5[12] <= sq_t'(t1_4) + s12_4;
      q_5[7] <= '0; q_5[11] <= '0; q_5[13] <= '0; q_5[14] <= '0; q_5[15] <= '0;
      m7_5 <= sq_t'(t1_4) + qmul(s7_4, t2_4);
      m11_5 <= sq_t'(t1_4) + qmul(s11_4, t2_4);
      m13_5 <= sq_t'(t1_4) + qmul(s13_4, t2_4);
      m14_5 <= sq_t'(t1_4) + qmul(s14_4, t2_4);
      m15_5 <= sq_t'(t1_4) + qmul(s15p_4, t2_4);
      f15_5 <= sq_t'(fmul(t2sq_4, a1111_4));
    end
  end

  // ---------------- stage 6: final scalings by g and t1
  logic v6;
  sq_t q_6 [NPAT];
  logic [1:0] ord6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (adv) v6 <= v5;
    if (adv) begin
      // plain terms pass through; the scaled ones are set below
      for (int i = 0; i < NPAT; i++) begin
        if (i != 7 && i != 11 && i < 13) q_6[i] <= q_5[i];
      end
      q_6[7] <= qmul(m7_5, g5);
      q_6[11] <= qmul(m11_5, g5);
      q_6[13] <= qmul(m13_5, g5);
      q_6[14] <= qmul(m14_5, g5);
      q_6[15] <= qmul(m15_5, t1_5) + f15_5;
      ord6 <= ord5;
    end
  end

  // ---------------- stage 7: 4-level butterfly (combinational, adds and subtracts only)
  typedef logic signed [40:0] wq_t;
  wq_t h [5][NPAT];
  always_comb begin
    for (int i = 0; i < NPAT; i++) h[0][i] = wq_t'(q_6[i]);
    for (int l = 0; l < 4; l++) begin
      for (int i = 0; i < NPAT; i++) begin
        if (i[l] == 1'b0) h[l+1][i] = h[l][i] + h[l][i | (1 << l)];
        else h[l+1][i] = h[l][i & ~(1 << l)] - h[l][i];
      end
    end
  end

  // round /16 and saturate
  function automatic logic signed [OUT_W-1:0] fin(input wq_t a);
    logic [40:0] mag;
    logic [40:0] r;
    wq_t v;
    mag = a[40] ? 41'(-a) : 41'(a);
    r = (mag + 41'd8) >> 4;
    v = a[40] ? wq_t'(-r) : wq_t'(r);
    if (v > wq_t'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < -wq_t'(33'sh0_8000_0000)) return 32'sh8000_0000;
    return v[OUT_W-1:0];
  endfunction

  // result bank: filled from the transform, drained one word per cycle while out_stall is low
  logic bank_full;
  logic [PW-1:0] cnt;
  logic signed [OUT_W-1:0] bank [NPAT];
  logic [1:0] bank_ord;
  logic drain_done;
  assign drain_done = bank_full && !out_stall && (cnt == PW'(NPAT - 1));
  assign adv = !v6 || !bank_full || drain_done;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_full <= 1'b0;
      cnt <= '0;
    end else if (v6 && adv) begin
      bank_full <= 1'b1;
      cnt <= '0;
    end else if (bank_full && !out_stall) begin
      cnt <= cnt + 1'b1;
      if (drain_done) bank_full <= 1'b0;
    end
    if (v6 && adv) begin
      for (int i = 0; i < NPAT; i++) bank[i] <= fin(h[4][i]);
      bank_ord <= ord6;
    end
  end

  assign out_valid = bank_full;
  assign pattern_index = cnt;
  assign probability = bank[src_index(bank_ord, cnt)];
  assign last_pattern = (cnt == PW'(NPAT - 1));
endmodule
`default_nettype wire

@@ tb/sv/sph_checker.sv @@
// Checker for site_pattern_probs_hadamard: watches both channels, predicts the
// sixteen probability words per parameter set and compares them. Depends on sph_pkg.
`default_nettype none
module sph_checker #(
  parameter int IN_FRAC_BITS = sph_pkg::IN_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire logic [IN_FRAC_BITS:0] gamma_factor,
  input  wire logic [IN_FRAC_BITS:0] edge_one,
  input  wire logic [IN_FRAC_BITS:0] edge_two,
  input  wire logic [IN_FRAC_BITS:0] edge_three,
  input  wire logic [IN_FRAC_BITS:0] edge_four,
  input  wire logic [IN_FRAC_BITS:0] edge_five,
  input  wire logic [1:0] leaf_order,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire logic [sph_pkg::PW-1:0] pattern_index,
  input  wire logic signed [sph_pkg::OUT_W-1:0] probability,
  input  wire logic last_pattern,
  output int errors,
  output int pending
);
  import sph_pkg::*;

  typedef longint unsigned u64_t;
  typedef struct {
    logic [PW-1:0] idx;
    logic signed [OUT_W-1:0] prob;
    logic last;
  } prob_word_t;

  localparam u64_t Q_ONE = u64_t'(1) << QBITS;
  localparam u64_t Q_HALF = u64_t'(1) << (QBITS - 1);

  prob_word_t expected_words[$];

  // Factor clamped to 1.0 and moved to Q30
  function automatic u64_t factor_q30(input logic [IN_FRAC_BITS:0] v);
    u64_t f;
    f = u64_t'(v);
    if (f > (u64_t'(1) << IN_FRAC_BITS)) f = u64_t'(1) << IN_FRAC_BITS;
    return f << (QBITS - IN_FRAC_BITS);
  endfunction

  function automatic u64_t fac_mul(input u64_t a, input u64_t b);
    return (a * b + Q_HALF) >> QBITS;
  endfunction

  // Signed Q30 times nonnegative factor, rounded half away from zero
  function automatic longint sgn_mul(input longint a, input u64_t b);
    u64_t mag;
    mag = (a < 0) ? u64_t'(-a) : u64_t'(a);
    mag = (mag * b + Q_HALF) >> QBITS;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint blend(input u64_t t1, input u64_t t2, input longint a);
    return longint'(t1) + sgn_mul(a, t2);
  endfunction

  // Predict the sixteen words of one parameter set
  task automatic predict_patterns(input logic [IN_FRAC_BITS:0] gi, x1i, x2i, x3i,
                                  x4i, x5i, input logic [1:0] ord);
    u64_t g, x1, x2, x3, x4, x5, x23, x12, t1, t2, a1111;
    longint a0011, a0101, a0110, a0111, a1001, a1010, a1100, a1101, a1110, dall, a1011;
    longint s, acc, gs;
    longint q[16];
    longint p[16];
    u64_t mag;
    logic [3:0] m, src;
    prob_word_t w;
    g = factor_q30(gi); x1 = factor_q30(x1i); x2 = factor_q30(x2i);
    x3 = factor_q30(x3i); x4 = factor_q30(x4i); x5 = factor_q30(x5i);
    x23 = fac_mul(x2, x3);
    x12 = fac_mul(x1, x2);
    a0011 = fac_mul(x4, x5);
    a0101 = fac_mul(x23, x4);
    a0110 = fac_mul(x23, x5);
    a0111 = fac_mul(fac_mul(a0011, x2), x3);
    a1001 = fac_mul(x12, x4);
    a1010 = fac_mul(x12, x5);
    a1100 = fac_mul(x1, x3);
    a1101 = fac_mul(a1001, x3);
    a1110 = fac_mul(a1010, x3);
    a1111 = fac_mul(a0011, a1100);
    dall = fac_mul(a1101, x5);
    a1011 = fac_mul(a1001, x5);
    t1 = fac_mul(g, g);
    t2 = Q_ONE - t1;
    gs = longint'(g);
    q[0] = longint'(Q_ONE);
    q[1] = gs; q[2] = gs; q[4] = gs; q[8] = gs;
    q[3] = blend(t1, t2, a0011);
    q[5] = blend(t1, t2, a0101);
    q[6] = blend(t1, t2, a0110);
    q[7] = sgn_mul(blend(t1, t2, a0011 + a0101 + a0110 - 2 * a0111), g);
    q[9] = blend(t1, t2, a1001);
    q[10] = blend(t1, t2, a1010);
    q[11] = sgn_mul(blend(t1, t2, a0011 + a1001 + a1010 - 2 * a1011), g);
    q[12] = blend(t1, t2, a1100);
    q[13] = sgn_mul(blend(t1, t2, a0101 + a1001 + a1100 - 2 * a1101), g);
    q[14] = sgn_mul(blend(t1, t2, a0110 + a1010 + a1100 - 2 * a1110), g);
    s = a0011 + a0101 + a0110 + a1001 + a1010 + a1100
        - 2 * (a0111 + a1011 + a1101 + a1110 - 2 * dall);
    q[15] = sgn_mul(blend(t1, t2, s), t1) + longint'(fac_mul(fac_mul(t2, t2), a1111));
    // Walsh-Hadamard, scaled by 1/16 with rounding, then saturated
    for (int i = 0; i < 16; i++) begin
      acc = 0;
      for (int j = 0; j < 16; j++) begin
        m = 4'(i & j);
        acc += (^m) ? -q[j] : q[j];
      end
      mag = (acc < 0) ? u64_t'(-acc) : u64_t'(acc);
      mag = (mag + 8) >> 4;
      p[i] = (acc < 0) ? -longint'(mag) : longint'(mag);
      if (p[i] > 64'sd2147483647) p[i] = 64'sd2147483647;
      if (p[i] < -64'sd2147483648) p[i] = -64'sd2147483648;
    end
    // Leaf reorder; code 3 falls back to identity
    for (int k = 0; k < 16; k++) begin
      m = 4'(k);
      case (ord)
        ORD_SWAP: src = {m[3], m[1], m[2], m[0]};
        ORD_CYCLE: src = {m[3], m[0], m[2], m[1]};
        default: src = m;
      endcase
      w.idx = m;
      w.prob = p[src][31:0];
      w.last = (k == 15);
      expected_words.push_back(w);
    end
  endtask

  // Predict on each accepted parameter set, compare each accepted word
  always @(posedge clk) begin
    prob_word_t e;
    if (rst) begin
      errors <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word idx=%0d prob=%0d", $time, pattern_index, probability);
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          if (e.idx !== pattern_index || e.prob !== probability || e.last !== last_pattern) begin
            $display("%0t: mismatch expected idx=%0d prob=%0d last=%0d, %s",
                     $time, e.idx, e.prob, e.last, "got");
            $display("%0t:   got idx=%0d prob=%0d last=%0d",
                     $time, pattern_index, probability, last_pattern);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_patterns(gamma_factor, edge_one, edge_two, edge_three, edge_four, edge_five,
                         leaf_order);
    end
    // words still owed by the block
    pending <= expected_words.size();
  end
endmodule
`default_nettype wire

@@ tb/sv/tb_site_pattern_probs_hadamard.sv @@
// Testbench top for site_pattern_probs_hadamard: clock, reset, stimulus, output stall
// and verdict. Depends on sph_pkg, the block and sph_checker.
`default_nettype none
module tb_site_pattern_probs_hadamard;
  import sph_pkg::*;
  localparam int IFB = IN_FRAC_BITS_DEF;
  localparam int ONE = 1 << IFB;
  localparam int MAXV = (1 << (IFB + 1)) - 1;

  typedef logic [IFB:0] fac_t;

  logic clk, rst, in_valid, in_stall, out_valid, out_stall, last_pattern;
  logic [IFB:0] gamma_factor, edge_one, edge_two, edge_three, edge_four, edge_five;
  logic [1:0] leaf_order;
  logic [PW-1:0] pattern_index;
  logic signed [OUT_W-1:0] probability;
  int errors, pending, cycles, stall_left;
  logic quiet;

  site_pattern_probs_hadamard dut (.*);
  sph_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stall per accepted word, none while quiet
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end else if (out_valid && !out_stall) begin
      n = quiet ? 0 : $urandom_range(0, 15);
      stall_left <= n;
      out_stall <= (n != 0);
    end
  end

  // Send one parameter set, keeping valid high across back-to-back sets
  task automatic send_set(input int g, x1, x2, x3, x4, x5, input int ord);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    gamma_factor <= fac_t'(g); edge_one <= fac_t'(x1); edge_two <= fac_t'(x2);
    edge_three <= fac_t'(x3); edge_four <= fac_t'(x4); edge_five <= fac_t'(x5);
    leaf_order <= 2'(ord);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic int rand_factor();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return ONE;
    if (r == 2) return $urandom_range(0, MAXV);
    return $urandom_range(0, ONE);
  endfunction

  initial begin
    cycles = 0;
    quiet = 0;
    rst = 1;
    in_valid = 0;
    gamma_factor = 0; edge_one = 0; edge_two = 0; edge_three = 0;
    edge_four = 0; edge_five = 0; leaf_order = ORD_IDENT;
    repeat (10) @(posedge clk);
    rst <= 0;
    // Directed: extremes, factors above one, every leaf order incl. code 3
    for (int o = 0; o < 4; o++) begin
      send_set(0, 0, 0, 0, 0, 0, o);
      send_set(ONE, ONE, ONE, ONE, ONE, ONE, o);
      send_set(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, o);
      send_set(MAXV - ONE, 21845, ONE, 0, 43690, ONE + 1, o);
    end
    send_set(ONE, 0, ONE, 0, ONE, 0, ORD_SWAP);
    send_set(0, ONE, ONE, ONE, ONE, ONE, ORD_CYCLE);
    send_set(ONE / 2, ONE - 1, 1, ONE - 1, 1, ONE - 1, ORD_IDENT);
    // Hold off until every word has drained
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Random, in phases with and without idling
    for (int i = 0; i < 160; i++) begin
      if (i % 40 == 0) quiet <= ~quiet;
      send_set(rand_factor(), rand_factor(), rand_factor(), rand_factor(),
               rand_factor(), rand_factor(), $urandom_range(0, 3));
    end
    in_valid <= 0;
    quiet <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

@@ site_pattern_probs_hadamard.f @@
rtl/sph_pkg.sv
rtl/site_pattern_probs_hadamard.sv
tb/sv/sph_checker.sv
tb/sv/tb_site_pattern_probs_hadamard.sv
